// File: hw/rtl/mhtq_pkg.sv
// shared types and constants for the min-heap timer queue
package mhtq_pkg;

   localparam int KEY_W       = 32;
   localparam int HDL_W       = 16;
   localparam int TIME_W      = 32;
   localparam int COUNT_OUT_W = 7;
   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 88;
   localparam int RSP_USER_W  = 2;

   // req_tuser codes
   localparam logic CMD_ADD = 1'b0;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [HDL_W-1:0] hdl;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic dispatch;
      logic up_step;
      logic up_cmp;
      logic chk_cmp;
      logic down_step;
      logic down_cmp;
      logic load_out;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_add;
      logic full;
      logic empty;
      logic at_root;
      logic up_move;
      logic expired;
      logic leaf;
      logic down_move;
   } dp_status_type;

endpackage

// File: hw/rtl/mhtq_ctrl.sv
// sequencing state machine for the timer heap
module mhtq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output mhtq_pkg::dp_cmd_type    dp_cmd,
   input  mhtq_pkg::dp_status_type dp_status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_UP_STEP,
      S_UP_CMP,
      S_CHK_CMP,
      S_DOWN_STEP,
      S_DOWN_CMP,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      dp_cmd       = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            dp_cmd.accept = req_tvalid;
            if (req_tvalid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            dp_cmd.dispatch = 1'b1;
            if (dp_status.is_add) begin
               state_in = dp_status.full ? S_RESP : S_UP_STEP;
            end else begin
               state_in = dp_status.empty ? S_RESP : S_CHK_CMP;
            end
         end
         S_UP_STEP: begin
            dp_cmd.up_step = 1'b1;
            state_in = dp_status.at_root ? S_RESP : S_UP_CMP;
         end
         S_UP_CMP: begin
            dp_cmd.up_cmp = 1'b1;
            state_in = dp_status.up_move ? S_UP_STEP : S_RESP;
         end
         S_CHK_CMP: begin
            dp_cmd.chk_cmp = 1'b1;
            state_in = dp_status.expired ? S_DOWN_STEP : S_RESP;
         end
         S_DOWN_STEP: begin
            dp_cmd.down_step = 1'b1;
            state_in = dp_status.leaf ? S_RESP : S_DOWN_CMP;
         end
         S_DOWN_CMP: begin
            dp_cmd.down_cmp = 1'b1;
            state_in = dp_status.down_move ? S_DOWN_STEP : S_RESP;
         end
         S_RESP: begin
            // wait for the output register to free up
            dp_cmd.load_out = out_free;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/mhtq_dpath.sv
// heap memory, hole pointer, compares and result registers
module mhtq_dpath #(
   parameter int HEAP_DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mhtq_pkg::dp_cmd_type                  dp_cmd,
   output mhtq_pkg::dp_status_type               dp_status,
   input  logic                                 in_cmd,
   input  logic [mhtq_pkg::KEY_W-1:0]            in_deadline,
   input  logic [mhtq_pkg::HDL_W-1:0]            in_handle,
   input  logic [mhtq_pkg::TIME_W-1:0]           in_now,
   output logic                                 out_fired,
   output logic [mhtq_pkg::HDL_W-1:0]            out_fired_handle,
   output logic [mhtq_pkg::KEY_W-1:0]            out_fired_deadline,
   output logic [mhtq_pkg::TIME_W-1:0]           out_wait_ms,
   output logic                                 out_rejected,
   output logic [mhtq_pkg::COUNT_OUT_W-1:0]      out_entry_count
);

   localparam int IDX_W = $clog2(HEAP_DEPTH);
   localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
   localparam int CHD_W = IDX_W + 2;

   mhtq_pkg::entry_type heap_mem [HEAP_DEPTH];
   mhtq_pkg::entry_type rd_a_ff, rd_b_ff;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   mhtq_pkg::entry_type cur_ff, cur_in;
   logic [mhtq_pkg::TIME_W-1:0] now_ff, now_in;
   logic              is_add_ff, is_add_in;
   logic              fired_ff, fired_in;
   logic              rej_ff, rej_in;
   mhtq_pkg::entry_type fired_ent_ff, fired_ent_in;
   logic [mhtq_pkg::TIME_W-1:0] wait_ff, wait_in;

   logic              o_fired_ff, o_fired_in;
   logic              o_rej_ff, o_rej_in;
   mhtq_pkg::entry_type o_ent_ff, o_ent_in;
   logic [mhtq_pkg::TIME_W-1:0] o_wait_ff, o_wait_in;
   logic [mhtq_pkg::COUNT_OUT_W-1:0] o_count_ff, o_count_in;

   logic [IDX_W-1:0]  parent_idx;
   logic [CNT_W-1:0]  last_w;
   logic [IDX_W:0]    left_w;
   logic [CHD_W-1:0]  right_w;
   logic [CHD_W-1:0]  count_x;
   logic              full, empty, at_root, up_move, expired, leaf, r_ok, l_less, r_pick;
   mhtq_pkg::entry_type best_ent;
   logic [IDX_W-1:0]  best_idx;

   logic [IDX_W-1:0]  rd_a_addr, rd_b_addr, wr_addr;
   mhtq_pkg::entry_type wr_data;
   logic              wr_en;

   assign full       = (count_ff == CNT_W'(HEAP_DEPTH));
   assign empty      = (count_ff == '0);
   assign parent_idx = (pos_ff - IDX_W'(1)) >> 1;
   assign last_w     = count_ff - CNT_W'(1);
   assign left_w     = {pos_ff, 1'b1};
   assign right_w    = CHD_W'(left_w) + CHD_W'(1);
   assign count_x    = CHD_W'(count_ff);
   assign at_root    = (pos_ff == '0);
   assign up_move    = (rd_a_ff.key > cur_ff.key);
   assign expired    = (now_ff > rd_a_ff.key);
   assign leaf       = (CHD_W'(left_w) >= count_x);
   assign r_ok       = (right_w < count_x);
   assign l_less     = (rd_a_ff.key < cur_ff.key);

   // left wins ties, right only when strictly smaller
   always_comb begin
      best_ent = cur_ff;
      best_idx = pos_ff;
      r_pick   = 1'b0;
      if (l_less) begin
         best_ent = rd_a_ff;
         best_idx = left_w[IDX_W-1:0];
      end
      if (r_ok && (rd_b_ff.key < best_ent.key)) begin
         best_ent = rd_b_ff;
         best_idx = right_w[IDX_W-1:0];
         r_pick   = 1'b1;
      end
   end

   always_comb begin
      dp_status           = '0;
      dp_status.is_add    = is_add_ff;
      dp_status.full      = full;
      dp_status.empty     = empty;
      dp_status.at_root   = at_root;
      dp_status.up_move   = up_move;
      dp_status.expired   = expired;
      dp_status.leaf      = leaf;
      dp_status.down_move = l_less || r_pick;
   end

   // memory port steering
   always_comb begin
      rd_a_addr = '0;
      rd_b_addr = '0;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = cur_ff;
      if (dp_cmd.dispatch) begin
         rd_b_addr = last_w[IDX_W-1:0];
      end
      if (dp_cmd.up_step) begin
         rd_a_addr = parent_idx;
         wr_en     = at_root;
      end
      if (dp_cmd.up_cmp) begin
         wr_en   = 1'b1;
         wr_data = up_move ? rd_a_ff : cur_ff;
      end
      if (dp_cmd.down_step) begin
         rd_a_addr = left_w[IDX_W-1:0];
         rd_b_addr = right_w[IDX_W-1:0];
         wr_en     = leaf;
      end
      if (dp_cmd.down_cmp) begin
         wr_en   = 1'b1;
         wr_data = best_ent;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) heap_mem[wr_addr] <= wr_data;
      rd_a_ff <= heap_mem[rd_a_addr];
      rd_b_ff <= heap_mem[rd_b_addr];
   end

   always_comb begin
      count_in     = count_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      now_in       = now_ff;
      is_add_in    = is_add_ff;
      fired_in     = fired_ff;
      rej_in       = rej_ff;
      fired_ent_in = fired_ent_ff;
      wait_in      = wait_ff;
      o_fired_in   = o_fired_ff;
      o_rej_in     = o_rej_ff;
      o_ent_in     = o_ent_ff;
      o_wait_in    = o_wait_ff;
      o_count_in   = o_count_ff;
      if (dp_cmd.accept) begin
         is_add_in    = (in_cmd == mhtq_pkg::CMD_ADD);
         cur_in.key   = in_deadline;
         cur_in.hdl   = in_handle;
         now_in       = in_now;
         pos_in       = count_ff[IDX_W-1:0];
         fired_in     = 1'b0;
         rej_in       = 1'b0;
         fired_ent_in = '0;
         wait_in      = '0;
      end
      if (dp_cmd.dispatch && is_add_ff) begin
         if (full) rej_in = 1'b1;
         else count_in = count_ff + CNT_W'(1);
      end
      if (dp_cmd.up_cmp && up_move) pos_in = parent_idx;
      if (dp_cmd.chk_cmp) begin
         if (expired) begin
            // last entry becomes the hole's occupant, walked down from the root
            fired_in     = 1'b1;
            fired_ent_in = rd_a_ff;
            cur_in       = rd_b_ff;
            count_in     = last_w;
            pos_in       = '0;
         end else begin
            wait_in = rd_a_ff.key - now_ff;
         end
      end
      if (dp_cmd.down_cmp) pos_in = best_idx;
      if (dp_cmd.load_out) begin
         o_fired_in = fired_ff;
         o_rej_in   = rej_ff;
         o_ent_in   = fired_ent_ff;
         o_wait_in  = wait_ff;
         o_count_in = mhtq_pkg::COUNT_OUT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      pos_ff       <= pos_in;
      cur_ff       <= cur_in;
      now_ff       <= now_in;
      is_add_ff    <= is_add_in;
      fired_ff     <= fired_in;
      rej_ff       <= rej_in;
      fired_ent_ff <= fired_ent_in;
      wait_ff      <= wait_in;
      o_fired_ff   <= o_fired_in;
      o_rej_ff     <= o_rej_in;
      o_ent_ff     <= o_ent_in;
      o_wait_ff    <= o_wait_in;
      o_count_ff   <= o_count_in;
   end

   assign out_fired          = o_fired_ff;
   assign out_fired_handle   = o_ent_ff.hdl;
   assign out_fired_deadline = o_ent_ff.key;
   assign out_wait_ms        = o_wait_ff;
   assign out_rejected       = o_rej_ff;
   assign out_entry_count    = o_count_ff;

endmodule

// File: hw/rtl/min_heap_timer_queue_core.sv
// timer queue top level: stream ports, controller and heap datapath
//
// Timer queue kept as a binary min-heap of (deadline, handle) pairs in a
// two-read, one-write memory of HEAP_DEPTH entries. An add item (tuser 0)
// inserts its pair and sifts it up; a full heap rejects the add. A check item
// (tuser 1) compares now_time with the earliest deadline as plain unsigned
// 32-bit values: if now is strictly later the root is returned as fired and
// removed, else the remaining wait is returned. Every item gives one result
// word. Items are processed one at a time: each heap level takes a memory
// read step, then a compare and write back step. An add climbs, and the
// entry moved by a firing check sinks, at most log2(HEAP_DEPTH) levels. A
// stalled output holds the finished item until the output register frees
// up. A new item is taken while a finished result still waits in the output
// register. After reset the heap is empty and ready.
module min_heap_timer_queue_core #(
   parameter int HEAP_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // deadline[31:0], handle[47:32], now_time[79:48]
   input  logic [mhtq_pkg::REQ_DATA_W-1:0]      req_tdata,
   // cmd: 0 add, 1 check
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // fired_handle[15:0], fired_deadline[47:16], wait_ms[79:48],
   // entry_count[86:80], zero[87]
   output logic [mhtq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // fired[0], rejected[1]
   output logic [mhtq_pkg::RSP_USER_W-1:0]      rsp_tuser
);

   mhtq_pkg::dp_cmd_type    dp_cmd;
   mhtq_pkg::dp_status_type dp_status;

   logic                               out_fired;
   logic [mhtq_pkg::HDL_W-1:0]          out_fired_handle;
   logic [mhtq_pkg::KEY_W-1:0]          out_fired_deadline;
   logic [mhtq_pkg::TIME_W-1:0]         out_wait_ms;
   logic                               out_rejected;
   logic [mhtq_pkg::COUNT_OUT_W-1:0]    out_entry_count;

   mhtq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status)
   );

   mhtq_dpath #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .dp_cmd             (dp_cmd),
      .dp_status          (dp_status),
      .in_cmd             (req_tuser),
      .in_deadline        (req_tdata[31:0]),
      .in_handle          (req_tdata[47:32]),
      .in_now             (req_tdata[79:48]),
      .out_fired          (out_fired),
      .out_fired_handle   (out_fired_handle),
      .out_fired_deadline (out_fired_deadline),
      .out_wait_ms        (out_wait_ms),
      .out_rejected       (out_rejected),
      .out_entry_count    (out_entry_count)
   );

   assign rsp_tdata = {1'b0, out_entry_count, out_wait_ms, out_fired_deadline,
                       out_fired_handle};
   assign rsp_tuser = {out_rejected, out_fired};

   // one item in flight: no second word taken straight after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while an item is in flight");

   a_fire_xor_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("result both fired and rejected");

   a_fire_no_wait: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[79:48] == '0))
      else $error("fired result carries a wait");

endmodule
